// ===== sv/tdrc_pkg.sv =====
// Package for the TCP destination rewrite and checksum block.
// Holds shared types, register codes, reset values and the ones'-complement add.
// No dependencies.
`default_nettype none

package tdrc_pkg;

  // Default sizing of the block.
  localparam int MAX_SEG_BYTES_DEF = 2048;
  localparam int POOL_SIZE_DEF     = 2;

  // Protocol constants.
  localparam logic [7:0]  TCP_PROTO  = 8'd6;
  localparam int          CKSUM_WORD = 8;
  localparam int          SUM_W      = 16;

  // Depth of the segment queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register indexes.
  localparam logic [2:0] REG_BALANCER_IP  = 3'd0;
  localparam logic [2:0] REG_SERVICE_PORT = 3'd1;
  localparam logic [2:0] REG_BACKEND_CNT  = 3'd2;
  localparam logic [2:0] REG_BACKEND_IP0  = 3'd3;
  localparam logic [2:0] REG_BACKEND_IP1  = 3'd4;

  // Register reset values.
  localparam logic [31:0] BALANCER_IP_RST  = 32'hC0A8_7AF7;
  localparam logic [15:0] SERVICE_PORT_RST = 16'd8003;
  localparam logic [1:0]  BACKEND_CNT_RST  = 2'd1;
  localparam logic [31:0] BACKEND_IP0_RST  = 32'hC0A8_7A23;
  localparam logic [31:0] BACKEND_IP1_RST  = 32'hA9FE_0917;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic [31:0] balancer_ip;
    logic [15:0] service_port;
    logic [1:0]  backend_count;
    logic [31:0] backend_ip_zero;
    logic [31:0] backend_ip_one;
  } cfg_t;

  // Summary of one finished segment, passed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [31:0]      src_ip;
    logic             src_port0;
    logic             match;
    logic             too_long;
    logic [SUM_W-1:0] len;
  } seg_rec_t;

  // 16-bit ones'-complement add with end-around carry.
  function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/tdrc_seg_if.sv =====
// Input channel of the block: one TCP segment word per item.
// No dependencies.
`default_nettype none

interface tdrc_seg_if;
  logic        valid;
  logic        ready;
  logic [15:0] seg_word;
  logic        odd_last;
  logic        last_word;
  logic [31:0] src_ip;
  logic [31:0] orig_dst_ip;
  logic [7:0]  ip_protocol;

  modport source (output valid, seg_word, odd_last, last_word, src_ip, orig_dst_ip,
                  ip_protocol, input ready);
  modport sink (input valid, seg_word, odd_last, last_word, src_ip, orig_dst_ip,
                ip_protocol, output ready);
endinterface

`default_nettype wire

// ===== sv/tdrc_res_if.sv =====
// Result channel of the block: one rewrite decision per segment.
// No dependencies.
`default_nettype none

interface tdrc_res_if;
  logic        valid;
  logic        ready;
  logic        forward;
  logic        backend_index;
  logic [31:0] new_dst_ip;
  logic [15:0] new_checksum;

  modport source (output valid, forward, backend_index, new_dst_ip, new_checksum,
                  input ready);
  modport sink (input valid, forward, backend_index, new_dst_ip, new_checksum,
                output ready);
endinterface

`default_nettype wire

// ===== sv/tdrc_cfg.sv =====
// Configuration registers behind the APB-style port.
// Depends on tdrc_pkg.
`default_nettype none

module tdrc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tdrc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [tdrc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [tdrc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                pready,
  output tdrc_pkg::cfg_t                      cfg
);
  import tdrc_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.balancer_ip     <= BALANCER_IP_RST;
      cfg_r.service_port    <= SERVICE_PORT_RST;
      cfg_r.backend_count   <= BACKEND_CNT_RST;
      cfg_r.backend_ip_zero <= BACKEND_IP0_RST;
      cfg_r.backend_ip_one  <= BACKEND_IP1_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_BALANCER_IP:  cfg_r.balancer_ip     <= pwdata;
        REG_SERVICE_PORT: cfg_r.service_port    <= pwdata[15:0];
        REG_BACKEND_CNT:  cfg_r.backend_count   <= pwdata[1:0];
        REG_BACKEND_IP0:  cfg_r.backend_ip_zero <= pwdata;
        REG_BACKEND_IP1:  cfg_r.backend_ip_one  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_idx)
      REG_BALANCER_IP:  prdata = cfg_r.balancer_ip;
      REG_SERVICE_PORT: prdata = {16'd0, cfg_r.service_port};
      REG_BACKEND_CNT:  prdata = {30'd0, cfg_r.backend_count};
      REG_BACKEND_IP0:  prdata = cfg_r.backend_ip_zero;
      REG_BACKEND_IP1:  prdata = cfg_r.backend_ip_one;
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/tdrc_front.sv =====
// Front part: accepts segment words, folds the running sum and classifies the segment.
// Depends on tdrc_pkg and tdrc_seg_if.
`default_nettype none

module tdrc_front #(
  parameter int MAX_SEG_BYTES = tdrc_pkg::MAX_SEG_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  tdrc_seg_if.sink              in_ch,
  input  wire tdrc_pkg::cfg_t   cfg,
  input  wire logic             q_full,
  output logic                  q_push,
  output tdrc_pkg::seg_rec_t    q_rec
);
  import tdrc_pkg::*;

  localparam int COUNT_CAP = MAX_SEG_BYTES / 2 + 2;
  localparam int CNT_W     = $clog2(COUNT_CAP + 1);
  localparam int LEN_W     = CNT_W + 1;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] wc_r, wc_nxt;
  logic [31:0]      src_ip_r, src_ip_cur;
  logic             port0_r, port0_cur;
  logic             hdr_r, hdr_cur;
  logic             pmatch_r, pmatch_cur;
  logic             accept, first, second;
  logic [15:0]      word_eff;
  logic [LEN_W-1:0] len_full;
  logic             too_long;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign first       = (wc_r == '0);
  assign second      = (wc_r == CNT_W'(1));

  // The odd final byte is padded with zero.
  assign word_eff = (in_ch.last_word && in_ch.odd_last) ?
                    {in_ch.seg_word[15:8], 8'h00} : in_ch.seg_word;

  // The checksum word position contributes nothing to the sum.
  assign sum_nxt = (wc_r != CNT_W'(CKSUM_WORD)) ? oc_add(sum_r, word_eff) : sum_r;
  assign wc_nxt  = (wc_r < CNT_W'(COUNT_CAP)) ? wc_r + CNT_W'(1) : wc_r;

  // Header fields seen on this word or held from earlier ones.
  assign src_ip_cur = first ? in_ch.src_ip : src_ip_r;
  assign port0_cur  = first ? in_ch.seg_word[0] : port0_r;
  assign hdr_cur    = first ? ((in_ch.orig_dst_ip == cfg.balancer_ip) &&
                               (in_ch.ip_protocol == TCP_PROTO)) : hdr_r;
  assign pmatch_cur = second ? (in_ch.seg_word == cfg.service_port) : pmatch_r;

  // Segment length in bytes and the overlength check.
  assign len_full = {wc_nxt, 1'b0} - {{CNT_W{1'b0}}, in_ch.odd_last};
  assign too_long = (wc_nxt >= CNT_W'(COUNT_CAP)) ||
                    (len_full > LEN_W'(MAX_SEG_BYTES));

  // Segment summary handed to the back on the last word.
  assign q_push          = accept && in_ch.last_word;
  assign q_rec.sum       = sum_nxt;
  assign q_rec.src_ip    = src_ip_cur;
  assign q_rec.src_port0 = port0_cur;
  assign q_rec.match     = hdr_cur && pmatch_cur && !too_long;
  assign q_rec.too_long  = too_long;
  assign q_rec.len       = SUM_W'(len_full);

  // Per-segment state, cleared after the last word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      wc_r     <= '0;
      src_ip_r <= '0;
      port0_r  <= 1'b0;
      hdr_r    <= 1'b0;
      pmatch_r <= 1'b0;
    end else if (accept) begin
      if (in_ch.last_word) begin
        sum_r    <= '0;
        wc_r     <= '0;
        src_ip_r <= '0;
        port0_r  <= 1'b0;
        hdr_r    <= 1'b0;
        pmatch_r <= 1'b0;
      end else begin
        sum_r    <= sum_nxt;
        wc_r     <= wc_nxt;
        src_ip_r <= src_ip_cur;
        port0_r  <= port0_cur;
        hdr_r    <= hdr_cur;
        pmatch_r <= pmatch_cur;
      end
    end
  end

  // The word count saturates at its cap.
  a_wc_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= CNT_W'(COUNT_CAP))
    else $error("word count above cap");

endmodule

`default_nettype wire

// ===== sv/tdrc_queue.sv =====
// Short queue of segment summaries between the front and the back.
// Depends on tdrc_pkg.
`default_nettype none

module tdrc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire tdrc_pkg::seg_rec_t push_rec,
  input  wire logic               pop,
  output tdrc_pkg::seg_rec_t      pop_rec,
  output logic                    full,
  output logic                    empty
);
  import tdrc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  seg_rec_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_rec = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== sv/tdrc_back.sv =====
// Back part: picks the backend, folds in the pseudo-header and holds the result.
// Depends on tdrc_pkg and tdrc_res_if.
`default_nettype none

module tdrc_back #(
  parameter int POOL_SIZE = tdrc_pkg::POOL_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tdrc_pkg::cfg_t     cfg,
  input  wire tdrc_pkg::seg_rec_t q_rec,
  input  wire logic               q_empty,
  output logic                    q_pop,
  tdrc_res_if.source              out_ch
);
  import tdrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ADD  = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  // Pseudo-header fold steps.
  localparam logic [1:0] STEP_SRC = 2'd0;
  localparam logic [1:0] STEP_DST = 2'd1;
  localparam logic [1:0] STEP_LEN = 2'd2;

  state_t           state_r, state_nxt;
  logic [1:0]       step_r;
  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0] term_a, term_b;
  seg_rec_t         rec_r;
  logic             idx_r, idx_sel;
  logic [31:0]      dst_r;
  logic             fwd_r;
  logic [SUM_W-1:0] cks_r;

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  // Backend choice: source port modulo the clamped backend count.
  assign idx_sel = (POOL_SIZE >= 2) && (cfg.backend_count >= 2'd2) && q_rec.src_port0;

  // Two pseudo-header terms per step.
  always_comb begin
    case (step_r)
      STEP_SRC: begin
        term_a = rec_r.src_ip[31:16];
        term_b = rec_r.src_ip[15:0];
      end
      STEP_DST: begin
        term_a = dst_r[31:16];
        term_b = dst_r[15:0];
      end
      default: begin
        term_a = {8'd0, TCP_PROTO};
        term_b = rec_r.len;
      end
    endcase
    acc_nxt = oc_add(oc_add(acc_r, term_a), term_b);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = S_ADD;
      S_ADD:   if (step_r == STEP_LEN) state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r  <= q_rec;
      acc_r  <= q_rec.sum;
      step_r <= STEP_SRC;
      idx_r  <= idx_sel;
      dst_r  <= idx_sel ? cfg.backend_ip_one : cfg.backend_ip_zero;
    end else if (state_r == S_ADD) begin
      acc_r  <= acc_nxt;
      step_r <= step_r + 2'd1;
      if (step_r == STEP_LEN) begin
        fwd_r <= rec_r.match;
        cks_r <= rec_r.too_long ? '0 : ~acc_nxt;
      end
    end
  end

  assign out_ch.valid         = (state_r == S_OUT);
  assign out_ch.forward       = fwd_r;
  assign out_ch.backend_index = idx_r;
  assign out_ch.new_dst_ip    = dst_r;
  assign out_ch.new_checksum  = cks_r;

  // A result appears only right after the last fold step.
  a_out_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(state_r == S_ADD && step_r == STEP_LEN))
    else $error("result without a finished fold");

  // The fold never runs past its last step.
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADD) |-> (step_r <= STEP_LEN))
    else $error("fold step out of range");

endmodule

`default_nettype wire

// ===== sv/tcp_dest_rewrite_checksum.sv =====
// TCP destination rewrite and checksum block, top level.
// Depends on tdrc_pkg, tdrc_seg_if, tdrc_res_if, tdrc_cfg, tdrc_front, tdrc_queue, tdrc_back.
//
// Usage:
//   in_ch carries one 16-bit segment word per item, first byte in the upper half;
//   src_ip, orig_dst_ip and ip_protocol are sampled on the first word of a segment,
//   last_word ends it and odd_last marks a single byte in its upper half.
//   out_ch carries one result per segment: forward flag, backend index, new
//   destination address and the TCP checksum over pseudo-header and segment.
//   Registers are written through the APB-style port at byte address 4*index; the user must
//   write them only while the block is idle, unchecked by the block; pready is always high.
// Timing:
//   The front takes one word per cycle while the queue is not full. The summary of
//   each segment is queued when its last word is taken. The back handles one segment
//   at a time: it takes the summary, runs three pseudo-header fold steps and holds the
//   result until taken, so segments shorter than five words are limited by the back.
//   A four-entry queue between front and back absorbs bursts of short segments.
// Reset and stall:
//   Reset (rst_n low, synchronous) loads register defaults and empties the queue.
//   While out_ch is stalled the result holds; the front keeps taking words until
//   the queue is full, then drops in_ch.ready.
`default_nettype none

module tcp_dest_rewrite_checksum #(
  parameter int MAX_SEG_BYTES = tdrc_pkg::MAX_SEG_BYTES_DEF,
  parameter int POOL_SIZE     = tdrc_pkg::POOL_SIZE_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  tdrc_seg_if.sink                             in_ch,
  tdrc_res_if.source                           out_ch,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tdrc_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [tdrc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [tdrc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready
);
  import tdrc_pkg::*;

  cfg_t     cfg;
  seg_rec_t push_rec, pop_rec;
  logic     q_push, q_pop, q_full, q_empty;

  // Configuration registers.
  tdrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Word intake and segment classification.
  tdrc_front #(
    .MAX_SEG_BYTES (MAX_SEG_BYTES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_rec  (push_rec)
  );

  // Segment summary queue.
  tdrc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .pop_rec  (pop_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Backend choice, pseudo-header fold and result register.
  tdrc_back #(
    .POOL_SIZE (POOL_SIZE)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_rec   (pop_rec),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
